@@ design/lfrs_pkg.sv @@
// shared widths, constants and unit request/response types for the line fit block
// no dependencies
package lfrs_pkg;

  localparam int MAX_POINTS = 256;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int COORD_W    = 16;
  localparam int SX_W       = CNT_W + 16;
  localparam int SXX_W      = CNT_W + 31;
  localparam int D_W        = (2 * CNT_W + 30 > 48) ? 2 * CNT_W + 30 : 48;
  localparam int CW         = D_W + 2;
  localparam int ST_W       = D_W - 36;
  localparam int DX_W       = CNT_W + 17;
  localparam int DXM_W      = CNT_W + 16;
  localparam int NUMM_W     = D_W + CNT_W + 17;
  localparam int R_W        = 48;
  localparam int SUM_W      = 64;
  localparam int RATIO_W    = 32;
  localparam int MA_W       = (D_W > R_W) ? D_W : R_W;
  localparam int MB_W       = (DXM_W > R_W) ? DXM_W : R_W;
  localparam int MP_W       = MA_W + MB_W;
  localparam int DN_W       = (NUMM_W + 16 > SUM_W) ? NUMM_W + 16 : SUM_W;
  localparam int DV_W       = (CNT_W + D_W > R_W) ? CNT_W + D_W : R_W;

  localparam logic [36:0] STEEP_LIMIT = 37'd100000000000;
  localparam logic signed [SUM_W-1:0] MINUS_ONE = -64'sd65536;
  localparam logic [R_W-1:0] R_MAX = {1'b0, {(R_W-1){1'b1}}};
  localparam logic [R_W-1:0] R_MIN = {1'b1, {(R_W-1){1'b0}}};
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [RATIO_W-1:0] RATIO_MAX = {1'b0, {(RATIO_W-1){1'b1}}};
  localparam logic [RATIO_W-1:0] RATIO_MIN = {1'b1, {(RATIO_W-1){1'b0}}};

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic            done;
    logic [MP_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic            start;
    logic [DN_W-1:0] num;
    logic [DV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DN_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ design/lfrs_ram.sv @@
// simple dual port point store, one write and one registered read port
// no dependencies
module lfrs_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/lfrs_mul.sv @@
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
// depends on lfrs_pkg
module lfrs_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  lfrs_pkg::mul_req_t req,
  output lfrs_pkg::mul_rsp_t rsp
);

  localparam int MC_W = $clog2(lfrs_pkg::MB_W + 1);

  logic                      busy_r;
  logic                      done_r;
  logic [MC_W-1:0]           cnt_r;
  logic [lfrs_pkg::MP_W-1:0] acc_r;
  logic [lfrs_pkg::MP_W-1:0] a_r;
  logic [lfrs_pkg::MB_W-1:0] b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && cnt_r == '0 && !req.start;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= MC_W'(lfrs_pkg::MB_W);
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - MC_W'(1);
        end else begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      a_r   <= lfrs_pkg::MP_W'(req.a);
      b_r   <= req.b;
    end else if (busy_r && cnt_r != '0) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

@@ design/lfrs_div.sv @@
// restoring divider, one quotient bit per cycle, quotient rounded half up
// depends on lfrs_pkg
module lfrs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lfrs_pkg::div_req_t req,
  output lfrs_pkg::div_rsp_t rsp
);

  localparam int DC_W = $clog2(lfrs_pkg::DN_W + 1);

  logic                      busy_r;
  logic                      done_r;
  logic [DC_W-1:0]           cnt_r;
  logic [lfrs_pkg::DN_W-1:0] num_r;
  logic [lfrs_pkg::DN_W-1:0] quo_r;
  logic [lfrs_pkg::DV_W-1:0] den_r;
  logic [lfrs_pkg::DV_W-1:0] rem_r;
  logic [lfrs_pkg::DV_W:0]   rem_sh;
  logic [lfrs_pkg::DV_W:0]   rem_sub;
  logic                      ge;
  logic                      round_up;

  assign rem_sh   = {rem_r, num_r[lfrs_pkg::DN_W-1]};
  assign ge       = rem_sh >= {1'b0, den_r};
  assign rem_sub  = rem_sh - {1'b0, den_r};
  assign round_up = {rem_r, 1'b0} >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && cnt_r == '0 && !req.start;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DC_W'(lfrs_pkg::DN_W);
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - DC_W'(1);
        end else begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_r <= ge ? rem_sub[lfrs_pkg::DV_W-1:0] : rem_sh[lfrs_pkg::DV_W-1:0];
        quo_r <= {quo_r[lfrs_pkg::DN_W-2:0], ge};
        num_r <= num_r << 1;
      end else begin
        // final remainder decides the half-up rounding
        quo_r <= quo_r + lfrs_pkg::DN_W'(round_up);
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ design/line_fit_residual_stats.sv @@
// line fit residual statistics: points load one per cycle into the point store while in_ready
// is high (only in the load state; points beyond MAX_POINTS are dropped); the last item of a
// segment starts the fit and then a reread pass over every stored point, built on the bit-serial
// multiplier (3 products, 1 for a steep fit) and the bit-serial divider; extended mode adds up to
// two divides; then the output register is loaded, where a result waits for ready.
// reset (rst_n low, synchronous) clears the segment sums, count, mode and output valid.
module line_fit_residual_stats (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_write_en,
  input  logic                                  cfg_write_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [lfrs_pkg::COORD_W-1:0]   in_point_x,
  input  logic signed [lfrs_pkg::COORD_W-1:0]   in_point_y,
  input  logic                                  in_last_point,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lfrs_pkg::SUM_W-1:0]     out_residual_sum_sq,
  output logic signed [lfrs_pkg::SUM_W-1:0]     out_mean_residual_sq,
  output logic signed [lfrs_pkg::R_W-1:0]       out_min_residual,
  output logic signed [lfrs_pkg::R_W-1:0]       out_max_residual,
  output logic signed [lfrs_pkg::RATIO_W-1:0]   out_min_over_max,
  output logic                                  out_too_few_points,
  output logic                                  out_points_dropped
);

  localparam int CNT_W  = lfrs_pkg::CNT_W;
  localparam int CW     = lfrs_pkg::CW;
  localparam int D_W    = lfrs_pkg::D_W;
  localparam int DX_W   = lfrs_pkg::DX_W;
  localparam int DXM_W  = lfrs_pkg::DXM_W;
  localparam int NUMM_W = lfrs_pkg::NUMM_W;
  localparam int R_W    = lfrs_pkg::R_W;
  localparam int MP_W   = lfrs_pkg::MP_W;
  localparam int DN_W   = lfrs_pkg::DN_W;
  localparam int DV_W   = lfrs_pkg::DV_W;
  localparam int SQ_W   = MP_W - 16;
  localparam int ST_W   = lfrs_pkg::ST_W;
  localparam int W2     = 2 * lfrs_pkg::COORD_W;

  typedef enum logic [4:0] {
    S_LOAD, S_FIT_MUL, S_FIT_SUB, S_FIT_DEN, S_RD, S_PT, S_NUM, S_M1, S_M2,
    S_DS, S_DR, S_SQ, S_SQW, S_MS, S_MW, S_RS, S_RW, S_EMIT
  } state_t;

  state_t state_r;

  logic                           ext_r;
  logic [CNT_W-1:0]               cnt_r;
  logic                           ovf_r;
  logic signed [lfrs_pkg::SX_W-1:0]  sx_r, sy_r;
  logic signed [lfrs_pkg::SXX_W-1:0] sxx_r, sxy_r;
  logic signed [CW-1:0]           t1_r, t2_r, t3_r, t4_r;
  logic [D_W-1:0]                 d_r, nm_mag_r;
  logic                           nm_neg_r;
  logic                           steep_r;
  logic [DV_W-1:0]                den_r;
  logic [CNT_W-1:0]               idx_r;
  logic signed [DX_W-1:0]         dxn_r, dyn_r;
  logic [MP_W-1:0]                p1_r;
  logic                           num_neg_r;
  logic [NUMM_W-1:0]              num_mag_r;
  logic signed [R_W-1:0]          r_r, lo_r, hi_r;
  logic [lfrs_pkg::SUM_W-1:0]     sum_r, mean_r;
  logic [lfrs_pkg::RATIO_W-1:0]   ratio_r;
  logic                           few_r;
  logic                           out_valid_r;
  logic [lfrs_pkg::SUM_W-1:0]     o_sum_r, o_mean_r;
  logic [R_W-1:0]                 o_min_r, o_max_r;
  logic [lfrs_pkg::RATIO_W-1:0]   o_ratio_r;
  logic                           o_few_r, o_drop_r;

  logic                           accept;
  logic                           room;
  logic signed [31:0]             x32, y32, xx, xy;
  logic [W2-1:0]                  rdata;
  logic signed [CW-1:0]           n_c, sx_c, sy_c, sxx_c, sxy_c, d_c, nm_c;
  logic [D_W:0]                   st_prod;
  logic                           steep_c;
  logic [DV_W-1:0]                n_v, d_v;
  logic signed [DX_W-1:0]         n_dx, xr, yr, sx_dx, sy_dx, dxn_c, dyn_c;
  logic [DXM_W-1:0]               dxn_abs, dyn_abs;
  logic signed [NUMM_W:0]         p1_s, p2_s, num_c;
  logic [R_W-1:0]                 r_abs, lo_abs;
  logic [DN_W-1:0]                q;
  logic                           q_big;
  logic [SQ_W-1:0]                sq;
  logic [SQ_W:0]                  sum_tmp;
  logic [CNT_W-1:0]               idx_nxt;
  logic                           emit_go;
  lfrs_pkg::mul_req_t             mul_req;
  lfrs_pkg::mul_rsp_t             mul_rsp;
  lfrs_pkg::div_req_t             div_req;
  lfrs_pkg::div_rsp_t             div_rsp;

  assign in_ready = (state_r == S_LOAD);
  assign accept   = in_valid && in_ready;
  assign room     = cnt_r < CNT_W'(lfrs_pkg::MAX_POINTS);

  assign x32 = 32'(in_point_x);
  assign y32 = 32'(in_point_y);
  assign xx  = x32 * x32;
  assign xy  = x32 * y32;

  lfrs_ram #(
    .DEPTH (lfrs_pkg::MAX_POINTS),
    .WIDTH (W2)
  ) u_ram (
    .clk   (clk),
    .we    (accept && room),
    .waddr (cnt_r[lfrs_pkg::ADDR_W-1:0]),
    .wdata ({in_point_x, in_point_y}),
    .re    (state_r == S_RD),
    .raddr (idx_r[lfrs_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  lfrs_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  lfrs_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // fit terms
  assign n_c   = $signed({{(CW-CNT_W){1'b0}}, cnt_r});
  assign sx_c  = CW'(sx_r);
  assign sy_c  = CW'(sy_r);
  assign sxx_c = CW'(sxx_r);
  assign sxy_c = CW'(sxy_r);
  assign d_c   = t1_r - t2_r;
  assign nm_c  = t3_r - t4_r;

  // steep test only matters for small d, beyond that the limit always covers |nm|
  assign st_prod = (D_W+1)'(d_r[ST_W-1:0]) * (D_W+1)'(lfrs_pkg::STEEP_LIMIT);
  assign steep_c = (d_r == '0) ||
                   ((d_r >> ST_W) == '0 && st_prod < {1'b0, nm_mag_r});
  assign n_v = DV_W'(cnt_r);
  assign d_v = DV_W'(d_r);

  // per point offsets
  assign n_dx  = $signed({{(DX_W-CNT_W){1'b0}}, cnt_r});
  assign xr    = DX_W'($signed(rdata[W2-1:lfrs_pkg::COORD_W]));
  assign yr    = DX_W'($signed(rdata[lfrs_pkg::COORD_W-1:0]));
  assign sx_dx = DX_W'(sx_r);
  assign sy_dx = DX_W'(sy_r);
  assign dxn_c = n_dx * xr - sx_dx;
  assign dyn_c = sy_dx - n_dx * yr;

  always_comb begin
    logic [DX_W-1:0] ax, ay;
    ax = dxn_r[DX_W-1] ? -dxn_r : dxn_r;
    ay = dyn_r[DX_W-1] ? -dyn_r : dyn_r;
    dxn_abs = ax[DXM_W-1:0];
    dyn_abs = ay[DXM_W-1:0];
  end

  // signed numerator from the two magnitude products
  always_comb begin
    logic signed [NUMM_W:0] m1, m2;
    m1 = $signed({1'b0, p1_r[NUMM_W-1:0]});
    m2 = $signed({1'b0, mul_rsp.prod[NUMM_W-1:0]});
    p1_s  = (nm_neg_r ^ dxn_r[DX_W-1]) ? -m1 : m1;
    p2_s  = dyn_r[DX_W-1] ? -m2 : m2;
    num_c = p1_s + p2_s;
  end

  assign r_abs  = r_r[R_W-1] ? -r_r : r_r;
  assign lo_abs = lo_r[R_W-1] ? -lo_r : lo_r;
  assign q      = div_rsp.quo;
  assign q_big  = q > DN_W'(lfrs_pkg::R_MAX);
  assign sq      = SQ_W'((mul_rsp.prod + MP_W'(32768)) >> 16);
  assign sum_tmp = (SQ_W+1)'(sum_r) + (SQ_W+1)'(sq);
  assign idx_nxt = idx_r + CNT_W'(1);
  assign emit_go = !out_valid_r || out_ready;

  always_comb begin
    mul_req = '0;
    case (state_r)
      S_NUM: begin
        mul_req.start = !steep_r;
        mul_req.a     = lfrs_pkg::MA_W'(nm_mag_r);
        mul_req.b     = lfrs_pkg::MB_W'(dxn_abs);
      end
      S_M1: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = lfrs_pkg::MA_W'(d_r);
        mul_req.b     = lfrs_pkg::MB_W'(dyn_abs);
      end
      S_SQ: begin
        mul_req.start = 1'b1;
        mul_req.a     = lfrs_pkg::MA_W'(r_abs);
        mul_req.b     = lfrs_pkg::MB_W'(r_abs);
      end
      default: mul_req = '0;
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state_r)
      S_DS: begin
        div_req.start = 1'b1;
        div_req.num   = DN_W'({num_mag_r, 16'b0});
        div_req.den   = den_r;
      end
      S_MS: begin
        div_req.start = 1'b1;
        div_req.num   = DN_W'(sum_r);
        div_req.den   = n_v;
      end
      S_RS: begin
        div_req.start = 1'b1;
        div_req.num   = DN_W'({lo_abs, 16'b0});
        div_req.den   = DV_W'(hi_r);
      end
      default: div_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      ext_r       <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      sx_r        <= '0;
      sy_r        <= '0;
      sxx_r       <= '0;
      sxy_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        ext_r <= cfg_write_data;
      end
      if (state_r == S_EMIT && emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              cnt_r <= cnt_r + CNT_W'(1);
              sx_r  <= sx_r + lfrs_pkg::SX_W'(in_point_x);
              sy_r  <= sy_r + lfrs_pkg::SX_W'(in_point_y);
              sxx_r <= sxx_r + lfrs_pkg::SXX_W'(xx);
              sxy_r <= sxy_r + lfrs_pkg::SXX_W'(xy);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_last_point) begin
              state_r <= S_FIT_MUL;
            end
          end
        end
        S_FIT_MUL: begin
          t1_r  <= n_c * sxx_c;
          t2_r  <= sx_c * sx_c;
          t3_r  <= n_c * sxy_c;
          t4_r  <= sx_c * sy_c;
          few_r <= cnt_r < CNT_W'(2);
          state_r <= (cnt_r < CNT_W'(2)) ? S_EMIT : S_FIT_SUB;
        end
        S_FIT_SUB: begin
          d_r      <= d_c[D_W-1:0];
          nm_neg_r <= nm_c[CW-1];
          nm_mag_r <= nm_c[CW-1] ? D_W'(-nm_c) : D_W'(nm_c);
          state_r  <= S_FIT_DEN;
        end
        S_FIT_DEN: begin
          steep_r <= steep_c;
          den_r   <= steep_c ? n_v : n_v * d_v;
          idx_r   <= '0;
          sum_r   <= '0;
          lo_r    <= '0;
          hi_r    <= '0;
          state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_PT;
        end
        S_PT: begin
          dxn_r   <= dxn_c;
          dyn_r   <= dyn_c;
          state_r <= S_NUM;
        end
        S_NUM: begin
          if (steep_r) begin
            num_neg_r <= dxn_r[DX_W-1];
            num_mag_r <= NUMM_W'(dxn_abs);
            state_r   <= S_DS;
          end else begin
            state_r <= S_M1;
          end
        end
        S_M1: begin
          if (mul_rsp.done) begin
            p1_r    <= mul_rsp.prod;
            state_r <= S_M2;
          end
        end
        S_M2: begin
          if (mul_rsp.done) begin
            num_neg_r <= num_c[NUMM_W];
            num_mag_r <= num_c[NUMM_W] ? NUMM_W'(-num_c) : NUMM_W'(num_c);
            state_r   <= S_DS;
          end
        end
        S_DS: begin
          state_r <= S_DR;
        end
        S_DR: begin
          if (div_rsp.done) begin
            if (num_neg_r) begin
              r_r <= q_big ? lfrs_pkg::R_MIN : -q[R_W-1:0];
            end else begin
              r_r <= q_big ? lfrs_pkg::R_MAX : q[R_W-1:0];
            end
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (idx_r == '0 || r_r < lo_r) begin
            lo_r <= r_r;
          end
          if (r_r > hi_r) begin
            hi_r <= r_r;
          end
          state_r <= S_SQW;
        end
        S_SQW: begin
          if (mul_rsp.done) begin
            // running sum sticks at the top once it saturates
            sum_r <= (sum_tmp > (SQ_W+1)'(lfrs_pkg::SUM_MAX)) ? lfrs_pkg::SUM_MAX
                                                               : sum_tmp[lfrs_pkg::SUM_W-1:0];
            idx_r <= idx_nxt;
            if (idx_nxt == cnt_r) begin
              mean_r  <= '0;
              ratio_r <= '0;
              state_r <= ext_r ? S_MS : S_EMIT;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_MS: begin
          state_r <= S_MW;
        end
        S_MW: begin
          if (div_rsp.done) begin
            mean_r  <= q[lfrs_pkg::SUM_W-1:0];
            state_r <= (hi_r == '0) ? S_EMIT : S_RS;
          end
        end
        S_RS: begin
          state_r <= S_RW;
        end
        S_RW: begin
          // ratio saturates to the 32 bit range
          if (div_rsp.done) begin
            if (lo_r[R_W-1]) begin
              ratio_r <= (q > DN_W'(lfrs_pkg::RATIO_MIN)) ? lfrs_pkg::RATIO_MIN
                                                           : -q[lfrs_pkg::RATIO_W-1:0];
            end else begin
              ratio_r <= (q > DN_W'(lfrs_pkg::RATIO_MAX)) ? lfrs_pkg::RATIO_MAX
                                                           : q[lfrs_pkg::RATIO_W-1:0];
            end
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            o_few_r     <= few_r;
            o_drop_r    <= ovf_r;
            if (few_r) begin
              o_sum_r   <= lfrs_pkg::MINUS_ONE;
              o_mean_r  <= lfrs_pkg::MINUS_ONE;
              o_min_r   <= lfrs_pkg::MINUS_ONE[R_W-1:0];
              o_max_r   <= lfrs_pkg::MINUS_ONE[R_W-1:0];
              o_ratio_r <= lfrs_pkg::MINUS_ONE[lfrs_pkg::RATIO_W-1:0];
            end else begin
              o_sum_r   <= sum_r;
              o_mean_r  <= ext_r ? mean_r : '0;
              o_min_r   <= ext_r ? lo_r : '0;
              o_max_r   <= ext_r ? hi_r : '0;
              o_ratio_r <= ext_r ? ratio_r : '0;
            end
            cnt_r   <= '0;
            ovf_r   <= 1'b0;
            sx_r    <= '0;
            sy_r    <= '0;
            sxx_r   <= '0;
            sxy_r   <= '0;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_residual_sum_sq  = o_sum_r;
  assign out_mean_residual_sq = o_mean_r;
  assign out_min_residual     = o_min_r;
  assign out_max_residual     = o_max_r;
  assign out_min_over_max     = o_ratio_r;
  assign out_too_few_points   = o_few_r;
  assign out_points_dropped   = o_drop_r;

endmodule

@@ design/lfrs_chk.sv @@
// port-level checker for the line fit block, attached to the top level by bind
// depends on line_fit_residual_stats ports
module lfrs_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [63:0] out_residual_sum_sq,
  input logic signed [47:0] out_max_residual,
  input logic               out_too_few_points
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_residual_sum_sq))
    else $error("result item changed while stalled");

  a_few: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_few_points |-> out_residual_sum_sq == -64'sd65536)
    else $error("too few points without minus one");

  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_too_few_points |-> out_residual_sum_sq >= 0)
    else $error("negative residual sum");

  a_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_too_few_points |-> out_max_residual >= 0)
    else $error("negative maximum residual");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind line_fit_residual_stats lfrs_chk u_lfrs_chk (.*);
